>>> hdl/blkmq_pkg.sv
// ============================================================================
// Blocking message queue package
// Sizes, status codes and the result beat type used by the queue top.
// ============================================================================
`default_nettype none

package blkmq_pkg;

   localparam int QUEUE_DEPTH  = 16;
   localparam int WAIT_DEPTH   = 16;
   localparam int MESSAGE_BITS = 32;

   localparam int TASK_W = 8;
   localparam int CAP_W  = 5;
   localparam int STAT_W = 2;

   localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int WPTR_W  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int WCNT_W  = $clog2(WAIT_DEPTH + 1);
   localparam int CMP_W   = (QCNT_W > CAP_W) ? QCNT_W : CAP_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   localparam logic KIND_SEND = 1'b0;
   localparam logic KIND_RECV = 1'b1;

   localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STAT_W-1:0] ST_QUEUED    = 2'd1;
   localparam logic [STAT_W-1:0] ST_LIST_FULL = 2'd2;

   typedef struct packed {
      logic [STAT_W-1:0]       status;
      logic [MESSAGE_BITS-1:0] message_out;
      logic                    wake_valid;
      logic [TASK_W-1:0]       wake_task;
   } blkmq_rsp_type;

endpackage

`default_nettype wire

>>> hdl/blocking_message_queue_top.sv
// ============================================================================
// Blocking message queue
// Task mailbox with a message ring and LIFO producer and consumer wait stacks.
// ============================================================================
// One request beat is taken per clock while req_stall is low; its result
// beat goes to the output register, or to the skid entry while rsp_stall
// holds the output. Ring slots and wait-stack tops are flip-flops, read and
// written in the same cycle, so only the result side sets the rate: an output
// register plus one skid entry keep req_stall low until two results wait.
`default_nettype none

module blocking_message_queue_top (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire                               req_kind,
   input  wire  [blkmq_pkg::TASK_W-1:0]       req_task_id,
   input  wire  [blkmq_pkg::MESSAGE_BITS-1:0] req_message_in,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [blkmq_pkg::STAT_W-1:0]       rsp_status,
   output logic [blkmq_pkg::MESSAGE_BITS-1:0] rsp_message_out,
   output logic                              rsp_wake_valid,
   output logic [blkmq_pkg::TASK_W-1:0]       rsp_wake_task,
   input  wire                               csr_wr_en,
   input  wire  [blkmq_pkg::CAP_W-1:0]        csr_wr_data
);
   import blkmq_pkg::*;

   logic [CAP_W-1:0]        capacity_ff;
   logic [MESSAGE_BITS-1:0] ring_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       rd_pos_ff, rd_pos_in;
   logic [QPTR_W-1:0]       wr_pos_ff, wr_pos_in;
   logic [QCNT_W-1:0]       fill_ff, fill_in;
   logic [TASK_W-1:0]       prod_wait_ff [WAIT_DEPTH];
   logic [TASK_W-1:0]       cons_wait_ff [WAIT_DEPTH];
   logic [WCNT_W-1:0]       prod_cnt_ff, prod_cnt_in;
   logic [WCNT_W-1:0]       cons_cnt_ff, cons_cnt_in;

   blkmq_rsp_type out_ff, out_in, skid_ff, skid_in, result;
   logic          out_valid_ff, out_valid_in;
   logic          skid_valid_ff, skid_valid_in;

   logic              req_accept, rsp_take;
   logic [QCNT_W-1:0] cap_eff;
   logic [QCNT_W-1:0] rd_next, wr_next;
   logic              ring_full, ring_empty;
   logic              prod_full, cons_full;
   logic              prod_push, cons_push, prod_pop, cons_pop;
   logic              ring_write;
   logic [WPTR_W-1:0] prod_top, cons_top;

   assign req_accept = req_valid && !skid_valid_ff;
   assign rsp_take   = out_valid_ff && !rsp_stall;
   assign req_stall  = skid_valid_ff;

   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = QCNT_W'(1);
      end else if (CMP_W'(capacity_ff) > CMP_W'(QUEUE_DEPTH)) begin
         cap_eff = QCNT_W'(QUEUE_DEPTH);
      end else begin
         cap_eff = QCNT_W'(capacity_ff);
      end
   end

   assign rd_next = QCNT_W'(rd_pos_ff) + QCNT_W'(1);
   assign wr_next = QCNT_W'(wr_pos_ff) + QCNT_W'(1);

   assign ring_full  = (fill_ff >= cap_eff);
   assign ring_empty = (fill_ff == '0);
   assign prod_full  = (prod_cnt_ff == WCNT_W'(WAIT_DEPTH));
   assign cons_full  = (cons_cnt_ff == WCNT_W'(WAIT_DEPTH));
   assign prod_top   = WPTR_W'(prod_cnt_ff - WCNT_W'(1));
   assign cons_top   = WPTR_W'(cons_cnt_ff - WCNT_W'(1));

   always_comb begin
      result      = '0;
      prod_push   = 1'b0;
      cons_push   = 1'b0;
      prod_pop    = 1'b0;
      cons_pop    = 1'b0;
      ring_write  = 1'b0;
      rd_pos_in   = rd_pos_ff;
      wr_pos_in   = wr_pos_ff;
      fill_in     = fill_ff;
      prod_cnt_in = prod_cnt_ff;
      cons_cnt_in = cons_cnt_ff;
      if (req_accept) begin
         if (req_kind == KIND_SEND) begin
            if (ring_full) begin
               prod_push     = !prod_full;
               result.status = prod_full ? ST_LIST_FULL : ST_QUEUED;
            end else begin
               ring_write = 1'b1;
               wr_pos_in  = (wr_next >= cap_eff) ? '0 : QPTR_W'(wr_next);
               fill_in    = fill_ff + QCNT_W'(1);
               cons_pop   = (cons_cnt_ff != '0);
               if (cons_pop) begin
                  result.wake_valid = 1'b1;
                  result.wake_task  = cons_wait_ff[cons_top];
               end
            end
         end else begin
            if (ring_empty) begin
               cons_push     = !cons_full;
               result.status = cons_full ? ST_LIST_FULL : ST_QUEUED;
            end else begin
               result.message_out = ring_ff[rd_pos_ff];
               rd_pos_in = (rd_next >= cap_eff) ? '0 : QPTR_W'(rd_next);
               fill_in   = fill_ff - QCNT_W'(1);
               prod_pop  = (prod_cnt_ff != '0);
               if (prod_pop) begin
                  result.wake_valid = 1'b1;
                  result.wake_task  = prod_wait_ff[prod_top];
               end
            end
         end
         if (prod_push) begin
            prod_cnt_in = prod_cnt_ff + WCNT_W'(1);
         end else if (prod_pop) begin
            prod_cnt_in = prod_cnt_ff - WCNT_W'(1);
         end
         if (cons_push) begin
            cons_cnt_in = cons_cnt_ff + WCNT_W'(1);
         end else if (cons_pop) begin
            cons_cnt_in = cons_cnt_ff - WCNT_W'(1);
         end
      end
   end

   // Output register with one skid entry behind it
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_accept) begin
         if (!out_valid_ff || rsp_take) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= CAP_RESET;
         rd_pos_ff     <= '0;
         wr_pos_ff     <= '0;
         fill_ff       <= '0;
         prod_cnt_ff   <= '0;
         cons_cnt_ff   <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         rd_pos_ff     <= rd_pos_in;
         wr_pos_ff     <= wr_pos_in;
         fill_ff       <= fill_in;
         prod_cnt_ff   <= prod_cnt_in;
         cons_cnt_ff   <= cons_cnt_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
      if (ring_write) begin
         ring_ff[wr_pos_ff] <= req_message_in;
      end
      if (prod_push) begin
         prod_wait_ff[WPTR_W'(prod_cnt_ff)] <= req_task_id;
      end
      if (cons_push) begin
         cons_wait_ff[WPTR_W'(cons_cnt_ff)] <= req_task_id;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_ff.status;
   assign rsp_message_out = out_ff.message_out;
   assign rsp_wake_valid  = out_ff.wake_valid;
   assign rsp_wake_task   = out_ff.wake_task;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without an output beat");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("fill count above ring depth");

   a_wait_bound: assert property (@(posedge clock) disable iff (reset)
      (prod_cnt_ff <= WCNT_W'(WAIT_DEPTH)) && (cons_cnt_ff <= WCNT_W'(WAIT_DEPTH)))
      else $error("wait count above stack depth");

   a_blocked_no_wake: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_DONE)) |-> (!rsp_wake_valid && rsp_message_out == '0))
      else $error("blocked beat carries a wake-up or a message");

endmodule

`default_nettype wire
